[sv/hoth_pkg.sv]
// ----------------------------------------------------------------------------
// hoth_pkg
// Shared types and constants for the HTTP-over-TCP header extractor: frame
// phases, result kinds, protocol byte values and the parser-to-emitter entry.
// ----------------------------------------------------------------------------
package hoth_pkg;

  localparam int POSITION_BITS     = 16;
  localparam int LINK_HEADER_BYTES = 14;

  typedef logic [POSITION_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  // parser-to-emitter queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
  typedef logic [QUEUE_AW-1:0] qptr_t;
  typedef logic [QUEUE_CW-1:0] qcount_t;

  // configuration port
  localparam int CFG_DATA_BITS = 16;
  typedef enum logic [0:0] {
    CFG_SERVER_PORT = 1'b0,
    CFG_BODY_ENABLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_LINK   = 3'd0,
    PH_IP     = 3'd1,
    PH_TCP    = 3'd2,
    PH_START  = 3'd3,
    PH_HEAD   = 3'd4,
    PH_BODY   = 3'd5,
    PH_IGNORE = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SUMMARY  = 3'd0,
    KIND_CHAR     = 3'd1,
    KIND_LINE_END = 3'd2,
    KIND_BODY     = 3'd3,
    KIND_PKT_END  = 3'd4
  } kind_t;

  localparam logic [7:0] CHAR_G  = 8'h47;
  localparam logic [7:0] CHAR_H  = 8'h48;
  localparam logic [7:0] CHAR_P  = 8'h50;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
  localparam int IP_SRC_OFF    = 12;
  localparam int IP_DST_OFF    = 16;
  localparam int TCP_DOFF_OFF  = 12;

  // one accepted byte's results: a first record, optionally followed by
  // a packet end (pair)
  typedef struct packed {
    kind_t       first_kind;
    logic [7:0]  ch;
    logic        mal;
    logic        pair;
    logic [31:0] pkt;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } entry_t;

endpackage

[sv/hoth_if.sv]
// ----------------------------------------------------------------------------
// hoth_in_if / hoth_out_if
// Valid/ready channels of the extractor: frame bytes in, result items out.
// ----------------------------------------------------------------------------
interface hoth_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink   (input valid, data_byte, frame_end, output ready);
endinterface

interface hoth_out_if;
  logic            valid;
  logic            ready;
  hoth_pkg::kind_t kind;
  logic [31:0]     packet_number;
  logic [31:0]     source_address;
  logic [31:0]     dest_address;
  logic [15:0]     source_tcp_port;
  logic [15:0]     dest_tcp_port;
  logic            is_response;
  logic [7:0]      char_out;
  logic            malformed;
  logic            run_last;

  modport source (output valid, kind, packet_number, source_address, dest_address,
                  source_tcp_port, dest_tcp_port, is_response, char_out, malformed,
                  run_last, input ready);
  modport sink   (input valid, kind, packet_number, source_address, dest_address,
                  source_tcp_port, dest_tcp_port, is_response, char_out, malformed,
                  run_last, output ready);
endinterface

[sv/hoth_parser.sv]
// ----------------------------------------------------------------------------
// hoth_parser
// Front end: takes one frame byte per cycle while the queue has room, walks
// the link/IP/TCP/HTTP phases and queues the results each byte causes.
// ----------------------------------------------------------------------------
module hoth_parser (
  input  logic             clk,
  input  logic             rst_n,
  hoth_in_if.sink          in_ch,
  input  logic             body_enable,
  input  logic             queue_full,
  output logic             push,
  output hoth_pkg::entry_t push_entry
);

  hoth_pkg::pos_t   pos_r, pos_nxt;
  hoth_pkg::phase_t phase_r, phase_nxt, phase_cur, phase_step;
  logic [3:0]       ip_words_r, ip_words_nxt;
  logic [3:0]       tcp_words_r, tcp_words_nxt;
  logic [31:0]      src_addr_r, src_addr_nxt;
  logic [31:0]      dst_addr_r, dst_addr_nxt;
  logic [15:0]      src_port_r, src_port_nxt;
  logic [15:0]      dst_port_r, dst_port_nxt;
  logic [31:0]      pkt_cnt_r, pkt_cnt_nxt;
  logic [7:0]       method_r, method_nxt;
  logic             skip_r, skip_nxt;
  logic             lwe_r, lwe_nxt;
  logic             bad_r, bad_nxt;

  logic             accept;
  logic             first;
  logic [7:0]       b;
  hoth_pkg::pos_t   off_ip;
  hoth_pkg::pos_t   off_tcp;
  logic [3:0]       ipw;
  logic [3:0]       tcpw;
  logic             ip_bad;
  logic             tcp_bad;
  logic             emit_a;
  hoth_pkg::kind_t  kind_a;
  logic [7:0]       ch_a;
  logic             mal;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign first       = (pos_r == '0);
  assign phase_cur   = first ? hoth_pkg::PH_LINK : phase_r;

  assign off_ip  = pos_r - hoth_pkg::pos_t'(hoth_pkg::LINK_HEADER_BYTES);
  assign off_tcp = off_ip - hoth_pkg::pos_t'({ip_words_r, 2'b00});
  assign ipw     = (off_ip == '0) ? b[3:0] : ip_words_r;
  assign tcpw    = (off_tcp == hoth_pkg::pos_t'(hoth_pkg::TCP_DOFF_OFF)) ? b[7:4]
                                                                         : tcp_words_r;
  assign ip_bad  = (off_ip == '0) && (b[3:0] < hoth_pkg::MIN_HDR_WORDS);
  assign tcp_bad = (off_tcp == hoth_pkg::pos_t'(hoth_pkg::TCP_DOFF_OFF)) &&
                   (b[7:4] < hoth_pkg::MIN_HDR_WORDS);

  always_comb begin
    // frame start clears the per-frame state
    phase_step    = phase_cur;
    ip_words_nxt  = first ? 4'd0 : ip_words_r;
    tcp_words_nxt = first ? 4'd0 : tcp_words_r;
    src_addr_nxt  = first ? 32'd0 : src_addr_r;
    dst_addr_nxt  = first ? 32'd0 : dst_addr_r;
    src_port_nxt  = first ? 16'd0 : src_port_r;
    dst_port_nxt  = first ? 16'd0 : dst_port_r;
    pkt_cnt_nxt   = first ? pkt_cnt_r + 32'd1 : pkt_cnt_r;
    method_nxt    = first ? 8'd0 : method_r;
    skip_nxt      = first ? 1'b0 : skip_r;
    lwe_nxt       = first ? 1'b0 : lwe_r;
    bad_nxt       = first ? 1'b0 : bad_r;
    emit_a        = 1'b0;
    kind_a        = hoth_pkg::KIND_SUMMARY;
    ch_a          = 8'd0;

    unique case (phase_cur)
      hoth_pkg::PH_LINK: begin
        if (pos_r >= hoth_pkg::pos_t'(hoth_pkg::LINK_HEADER_BYTES - 1))
          phase_step = hoth_pkg::PH_IP;
      end
      hoth_pkg::PH_IP: begin
        if (off_ip == '0) ip_words_nxt = b[3:0];
        if (ip_bad) begin
          bad_nxt    = 1'b1;
          phase_step = hoth_pkg::PH_IGNORE;
        end else begin
          if (off_ip >= hoth_pkg::pos_t'(hoth_pkg::IP_SRC_OFF) &&
              off_ip <= hoth_pkg::pos_t'(hoth_pkg::IP_SRC_OFF + 3))
            src_addr_nxt = {src_addr_r[23:0], b};
          else if (off_ip >= hoth_pkg::pos_t'(hoth_pkg::IP_DST_OFF) &&
                   off_ip <= hoth_pkg::pos_t'(hoth_pkg::IP_DST_OFF + 3))
            dst_addr_nxt = {dst_addr_r[23:0], b};
          if (off_ip >= hoth_pkg::pos_t'({ipw, 2'b00} - 6'd1))
            phase_step = hoth_pkg::PH_TCP;
        end
      end
      hoth_pkg::PH_TCP: begin
        if (off_tcp <= hoth_pkg::pos_t'(1))
          src_port_nxt = {src_port_r[7:0], b};
        else if (off_tcp <= hoth_pkg::pos_t'(3))
          dst_port_nxt = {dst_port_r[7:0], b};
        else if (off_tcp == hoth_pkg::pos_t'(hoth_pkg::TCP_DOFF_OFF))
          tcp_words_nxt = b[7:4];
        if (tcp_bad) begin
          bad_nxt    = 1'b1;
          phase_step = hoth_pkg::PH_IGNORE;
        end else if (off_tcp >= hoth_pkg::pos_t'(hoth_pkg::TCP_DOFF_OFF) &&
                     off_tcp >= hoth_pkg::pos_t'({tcpw, 2'b00} - 6'd1)) begin
          emit_a     = 1'b1;
          kind_a     = hoth_pkg::KIND_SUMMARY;
          phase_step = hoth_pkg::PH_START;
        end
      end
      hoth_pkg::PH_START: begin
        method_nxt = b;
        if (b == hoth_pkg::CHAR_G || b == hoth_pkg::CHAR_H || b == hoth_pkg::CHAR_P) begin
          emit_a     = 1'b1;
          kind_a     = hoth_pkg::KIND_CHAR;
          ch_a       = b;
          lwe_nxt    = 1'b0;
          skip_nxt   = 1'b0;
          phase_step = hoth_pkg::PH_HEAD;
        end else begin
          phase_step = hoth_pkg::PH_IGNORE;
        end
      end
      hoth_pkg::PH_HEAD: begin
        if (skip_r) begin
          skip_nxt = 1'b0;
        end else if (b == hoth_pkg::CHAR_CR) begin
          emit_a   = 1'b1;
          kind_a   = hoth_pkg::KIND_LINE_END;
          skip_nxt = 1'b1;
          // second CR with nothing between: blank line ends the headers
          if (lwe_r)
            phase_step = (method_r == hoth_pkg::CHAR_P && body_enable) ? hoth_pkg::PH_BODY
                                                                       : hoth_pkg::PH_IGNORE;
          lwe_nxt = 1'b1;
        end else begin
          emit_a  = 1'b1;
          kind_a  = hoth_pkg::KIND_CHAR;
          ch_a    = b;
          lwe_nxt = 1'b0;
        end
      end
      hoth_pkg::PH_BODY: begin
        if (skip_r) begin
          skip_nxt = 1'b0;
        end else begin
          emit_a = 1'b1;
          kind_a = hoth_pkg::KIND_BODY;
          ch_a   = b;
        end
      end
      default: begin
      end
    endcase

    mal = bad_nxt || phase_step == hoth_pkg::PH_LINK || phase_step == hoth_pkg::PH_IP ||
          phase_step == hoth_pkg::PH_TCP;

    phase_nxt = phase_step;
    pos_nxt   = pos_r;
    if (in_ch.frame_end) begin
      pos_nxt   = '0;
      phase_nxt = hoth_pkg::PH_LINK;
    end else if (pos_r != hoth_pkg::POS_MAX) begin
      pos_nxt = pos_r + hoth_pkg::pos_t'(1);
    end

    push                  = accept && (emit_a || in_ch.frame_end);
    push_entry.first_kind = emit_a ? kind_a : hoth_pkg::KIND_PKT_END;
    push_entry.ch         = emit_a ? ch_a : 8'd0;
    push_entry.mal        = mal;
    push_entry.pair       = emit_a && in_ch.frame_end;
    push_entry.pkt        = pkt_cnt_nxt;
    push_entry.src        = src_addr_nxt;
    push_entry.dst        = dst_addr_nxt;
    push_entry.sport      = src_port_nxt;
    push_entry.dport      = dst_port_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      phase_r     <= hoth_pkg::PH_LINK;
      ip_words_r  <= 4'd0;
      tcp_words_r <= 4'd0;
      pkt_cnt_r   <= 32'd0;
      method_r    <= 8'd0;
      skip_r      <= 1'b0;
      lwe_r       <= 1'b0;
      bad_r       <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      ip_words_r  <= ip_words_nxt;
      tcp_words_r <= tcp_words_nxt;
      pkt_cnt_r   <= pkt_cnt_nxt;
      method_r    <= method_nxt;
      skip_r      <= skip_nxt;
      lwe_r       <= lwe_nxt;
      bad_r       <= bad_nxt;
    end
  end

  // captured header fields; cleared on each frame start
  always_ff @(posedge clk) begin
    if (accept) begin
      src_addr_r <= src_addr_nxt;
      dst_addr_r <= dst_addr_nxt;
      src_port_r <= src_port_nxt;
      dst_port_r <= dst_port_nxt;
    end
  end

  a_bad_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    bad_r && pos_r != '0 |-> phase_r == hoth_pkg::PH_IGNORE)
    else $error("bad header length but parser not ignoring rest of frame");

endmodule

[sv/hoth_fifo.sv]
// ----------------------------------------------------------------------------
// hoth_fifo
// Short queue between parser and emitter; each entry holds the results of
// one frame byte.
// ----------------------------------------------------------------------------
module hoth_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hoth_pkg::entry_t push_entry,
  input  logic             pop,
  output hoth_pkg::entry_t head,
  output logic             head_valid,
  output logic             full
);

  hoth_pkg::entry_t   mem_r [hoth_pkg::QUEUE_DEPTH];
  hoth_pkg::qptr_t    wr_ptr_r, wr_ptr_nxt;
  hoth_pkg::qptr_t    rd_ptr_r, rd_ptr_nxt;
  hoth_pkg::qcount_t  count_r, count_nxt;

  localparam hoth_pkg::qptr_t LAST_SLOT = hoth_pkg::qptr_t'(hoth_pkg::QUEUE_DEPTH - 1);
  localparam hoth_pkg::qcount_t DEPTH_C = hoth_pkg::qcount_t'(hoth_pkg::QUEUE_DEPTH);

  assign head       = mem_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == DEPTH_C);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + hoth_pkg::qptr_t'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + hoth_pkg::qptr_t'(1);
    case ({push, pop})
      2'b10:   count_nxt = count_r + hoth_pkg::qcount_t'(1);
      2'b01:   count_nxt = count_r - hoth_pkg::qcount_t'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

[sv/hoth_emitter.sv]
// ----------------------------------------------------------------------------
// hoth_emitter
// Back end: unpacks queued entries into result items, one per cycle while
// out_ch.ready does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
module hoth_emitter (
  input  logic             clk,
  input  logic             rst_n,
  input  hoth_pkg::entry_t head,
  input  logic             head_valid,
  input  logic [15:0]      server_port,
  output logic             pop,
  hoth_out_if.source       out_ch
);

  logic            out_valid_r, out_valid_nxt;
  logic            sub_r, sub_nxt;
  hoth_pkg::kind_t kind_r;
  logic [31:0]     pkt_r, src_r, dst_r;
  logic [15:0]     sport_r, dport_r;
  logic            resp_r;
  logic [7:0]      ch_r;
  logic            mal_r;
  logic            last_r;

  logic            load;
  logic            take;
  hoth_pkg::kind_t rec_kind;

  assign load     = !out_valid_r || out_ch.ready;
  assign take     = load && head_valid;
  // second half of a pair is always the packet end
  assign rec_kind = sub_r ? hoth_pkg::KIND_PKT_END : head.first_kind;

  always_comb begin
    pop           = take && (sub_r || !head.pair);
    sub_nxt       = take ? (!sub_r && head.pair) : sub_r;
    out_valid_nxt = load ? head_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= rec_kind;
      pkt_r   <= head.pkt;
      src_r   <= head.src;
      dst_r   <= head.dst;
      sport_r <= head.sport;
      dport_r <= head.dport;
      resp_r  <= (head.sport == server_port);
      ch_r    <= sub_r ? 8'd0 : head.ch;
      mal_r   <= (rec_kind == hoth_pkg::KIND_PKT_END) ? head.mal : 1'b0;
      last_r  <= sub_r || !head.pair;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = kind_r;
  assign out_ch.packet_number   = pkt_r;
  assign out_ch.source_address  = src_r;
  assign out_ch.dest_address    = dst_r;
  assign out_ch.source_tcp_port = sport_r;
  assign out_ch.dest_tcp_port   = dport_r;
  assign out_ch.is_response     = resp_r;
  assign out_ch.char_out        = ch_r;
  assign out_ch.malformed       = mal_r;
  assign out_ch.run_last        = last_r;

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == hoth_pkg::KIND_PKT_END |-> last_r)
    else $error("packet end not marked as last result of its byte");

  a_mal_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != hoth_pkg::KIND_PKT_END |-> !mal_r)
    else $error("malformed flag on a non packet-end item");

endmodule

[sv/http_over_tcp_header_extractor.sv]
// ----------------------------------------------------------------------------
// http_over_tcp_header_extractor
// Parses captured Ethernet/IPv4/TCP frames a byte at a time and emits a
// summary, HTTP header characters, line ends, body bytes and packet ends.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one frame byte per item, frame_end set on the last byte.
//   out_ch : result items; a byte causes zero, one or two items, and
//            run_last marks the final item of each byte.
//   cfg_*  : write-only registers (server port, body enable); the user must write
//            them only while the block is idle, the block itself does not enforce it.
// Timing: a byte is taken each clock while the parser-to-emitter queue
//   (4 entries) has room. Its results pass through the queue and then the
//   registered output stage. Output runs at one item per clock while
//   out_ch.ready is high, so a byte that causes two items (any item plus the
//   frame end) holds the output for both items; the queue absorbs these.
// Reset: synchronous; parser starts in the link header phase, packet count
//   is zero, queue and output stage are empty, registers take 80 and 1.
// Output stall: the output register holds; the queue fills and in_ch.ready
//   drops once it is full.
// ----------------------------------------------------------------------------
module http_over_tcp_header_extractor (
  input  logic                               clk,
  input  logic                               rst_n,
  hoth_in_if.sink                            in_ch,
  hoth_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  hoth_pkg::cfg_reg_t                 cfg_index,
  input  logic [hoth_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  logic [15:0]      server_port_r;
  logic             body_enable_r;

  logic             push;
  logic             pop;
  logic             full;
  logic             head_valid;
  hoth_pkg::entry_t push_entry;
  hoth_pkg::entry_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r <= 16'd80;
      body_enable_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hoth_pkg::CFG_SERVER_PORT: server_port_r <= cfg_wdata[15:0];
        hoth_pkg::CFG_BODY_ENABLE: body_enable_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  hoth_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .body_enable(body_enable_r),
    .queue_full (full),
    .push       (push),
    .push_entry (push_entry)
  );

  hoth_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .full      (full)
  );

  hoth_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .server_port(server_port_r),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

[tb/http_over_tcp_header_extractor_tb.sv]
// ----------------------------------------------------------------------------
// http_over_tcp_header_extractor_tb
// Drives Ethernet/IPv4/TCP frames a byte at a time through the extractor and
// checks every result item against a byte-level model of the parser. Frames
// range from well-formed HTTP requests and responses to truncated, bad-length
// and non-HTTP frames. Both channels idle and stall at random, across several
// register settings.
// ----------------------------------------------------------------------------
typedef struct {
  hoth_pkg::kind_t kind;
  logic [31:0]     pkt;
  logic [31:0]     src;
  logic [31:0]     dst;
  logic [15:0]     sport;
  logic [15:0]     dport;
  logic            resp;
  logic [7:0]      ch;
  logic            mal;
  logic            last;
} hoth_record_t;

class extract_scoreboard;
  hoth_record_t     pending[$];
  int               errors;

  logic [15:0]      srv_port;
  logic             body_en;

  hoth_pkg::pos_t   pos;
  hoth_pkg::phase_t ph;
  int unsigned      ip_w;
  int unsigned      tcp_w;
  logic [31:0]      src_addr;
  logic [31:0]      dst_addr;
  logic [15:0]      sport;
  logic [15:0]      dport;
  logic [31:0]      pkt_count;
  logic [7:0]       method;
  logic             skip_next;
  logic             empty_line;
  logic             bad_len;

  function new();
    srv_port   = 16'd80;
    body_en    = 1'b1;
    pos        = '0;
    ph         = hoth_pkg::PH_LINK;
    ip_w       = 0;
    tcp_w      = 0;
    src_addr   = '0;
    dst_addr   = '0;
    sport      = '0;
    dport      = '0;
    pkt_count  = '0;
    method     = '0;
    skip_next  = 1'b0;
    empty_line = 1'b0;
    bad_len    = 1'b0;
    errors     = 0;
  endfunction

  function void write_reg(hoth_pkg::cfg_reg_t idx, logic [15:0] v);
    if (idx == hoth_pkg::CFG_SERVER_PORT) srv_port = v;
    else body_en = v[0];
  endfunction

  function int outstanding();
    return pending.size();
  endfunction

  function void push_record(hoth_pkg::kind_t k, logic [7:0] c, logic m);
    hoth_record_t r;
    r.kind  = k;
    r.pkt   = pkt_count;
    r.src   = src_addr;
    r.dst   = dst_addr;
    r.sport = sport;
    r.dport = dport;
    r.resp  = (sport == srv_port);
    r.ch    = c;
    r.mal   = m;
    r.last  = 1'b0;
    pending.push_back(r);
  endfunction

  // advance the parser by one accepted byte and queue what it emits
  function void take_byte(logic [7:0] b, logic last);
    int unsigned off;
    int          n0;
    n0 = pending.size();
    if (pos == 0) begin
      pkt_count  = pkt_count + 1;
      ph         = hoth_pkg::PH_LINK;
      ip_w       = 0;
      tcp_w      = 0;
      src_addr   = '0;
      dst_addr   = '0;
      sport      = '0;
      dport      = '0;
      method     = '0;
      skip_next  = 1'b0;
      empty_line = 1'b0;
      bad_len    = 1'b0;
    end
    case (ph)
      hoth_pkg::PH_LINK: begin
        if (pos >= hoth_pkg::LINK_HEADER_BYTES - 1) ph = hoth_pkg::PH_IP;
      end
      hoth_pkg::PH_IP: begin
        off = pos - hoth_pkg::LINK_HEADER_BYTES;
        if (off == 0) ip_w = b[3:0];
        if (off == 0 && ip_w < hoth_pkg::MIN_HDR_WORDS) begin
          bad_len = 1'b1;
          ph      = hoth_pkg::PH_IGNORE;
        end else begin
          if (off >= hoth_pkg::IP_SRC_OFF && off < hoth_pkg::IP_SRC_OFF + 4)
            src_addr = {src_addr[23:0], b};
          else if (off >= hoth_pkg::IP_DST_OFF && off < hoth_pkg::IP_DST_OFF + 4)
            dst_addr = {dst_addr[23:0], b};
          if (off >= ip_w * 4 - 1) ph = hoth_pkg::PH_TCP;
        end
      end
      hoth_pkg::PH_TCP: begin
        off = pos - hoth_pkg::LINK_HEADER_BYTES - ip_w * 4;
        if (off <= 1) sport = {sport[7:0], b};
        else if (off <= 3) dport = {dport[7:0], b};
        else if (off == hoth_pkg::TCP_DOFF_OFF) begin
          tcp_w = b[7:4];
          if (tcp_w < hoth_pkg::MIN_HDR_WORDS) begin
            bad_len = 1'b1;
            ph      = hoth_pkg::PH_IGNORE;
          end
        end
        if (ph == hoth_pkg::PH_TCP && off >= hoth_pkg::TCP_DOFF_OFF &&
            off >= tcp_w * 4 - 1) begin
          push_record(hoth_pkg::KIND_SUMMARY, 8'd0, 1'b0);
          ph = hoth_pkg::PH_START;
        end
      end
      hoth_pkg::PH_START: begin
        method = b;
        if (b == hoth_pkg::CHAR_G || b == hoth_pkg::CHAR_H || b == hoth_pkg::CHAR_P) begin
          push_record(hoth_pkg::KIND_CHAR, b, 1'b0);
          empty_line = 1'b0;
          skip_next  = 1'b0;
          ph         = hoth_pkg::PH_HEAD;
        end else begin
          ph = hoth_pkg::PH_IGNORE;
        end
      end
      hoth_pkg::PH_HEAD: begin
        if (skip_next) begin
          skip_next = 1'b0;
        end else if (b == hoth_pkg::CHAR_CR) begin
          push_record(hoth_pkg::KIND_LINE_END, 8'd0, 1'b0);
          skip_next = 1'b1;
          // second CR in a row (LF skipped in between) closes the headers
          if (empty_line)
            ph = (method == hoth_pkg::CHAR_P && body_en) ? hoth_pkg::PH_BODY
                                                          : hoth_pkg::PH_IGNORE;
          empty_line = 1'b1;
        end else begin
          push_record(hoth_pkg::KIND_CHAR, b, 1'b0);
          empty_line = 1'b0;
        end
      end
      hoth_pkg::PH_BODY: begin
        if (skip_next) skip_next = 1'b0;
        else push_record(hoth_pkg::KIND_BODY, b, 1'b0);
      end
      default: ;
    endcase
    if (last) begin
      push_record(hoth_pkg::KIND_PKT_END, 8'd0,
                  bad_len || (ph inside {hoth_pkg::PH_LINK, hoth_pkg::PH_IP,
                                         hoth_pkg::PH_TCP}));
      pos = '0;
      ph  = hoth_pkg::PH_LINK;
    end else if (pos != hoth_pkg::POS_MAX) begin
      pos = pos + 1'b1;
    end
    if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task match_record(hoth_record_t got);
    hoth_record_t exp;
    if (pending.size() == 0) begin
      report($sformatf("unexpected item, kind %0d pkt %0d", got.kind, got.pkt));
      return;
    end
    exp = pending.pop_front();
    if (got.kind !== exp.kind)
      report($sformatf("pkt %0d kind %0d, want %0d", exp.pkt, got.kind, exp.kind));
    if (got.pkt !== exp.pkt)
      report($sformatf("packet_number %0d, want %0d", got.pkt, exp.pkt));
    if (got.src !== exp.src)
      report($sformatf("pkt %0d source_address %h, want %h", exp.pkt, got.src, exp.src));
    if (got.dst !== exp.dst)
      report($sformatf("pkt %0d dest_address %h, want %h", exp.pkt, got.dst, exp.dst));
    if (got.sport !== exp.sport)
      report($sformatf("pkt %0d source port %h, want %h", exp.pkt, got.sport, exp.sport));
    if (got.dport !== exp.dport)
      report($sformatf("pkt %0d dest port %h, want %h", exp.pkt, got.dport, exp.dport));
    if (got.resp !== exp.resp)
      report($sformatf("pkt %0d is_response %b, want %b", exp.pkt, got.resp, exp.resp));
    if (got.ch !== exp.ch)
      report($sformatf("pkt %0d char_out %h, want %h", exp.pkt, got.ch, exp.ch));
    if (got.mal !== exp.mal)
      report($sformatf("pkt %0d malformed %b, want %b", exp.pkt, got.mal, exp.mal));
    if (got.last !== exp.last)
      report($sformatf("pkt %0d run_last %b, want %b", exp.pkt, got.last, exp.last));
  endtask
endclass

module http_over_tcp_header_extractor_tb;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic                               cfg_we;
  hoth_pkg::cfg_reg_t                 cfg_index;
  logic [hoth_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  hoth_in_if  in_ch ();
  hoth_out_if out_ch ();

  http_over_tcp_header_extractor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  extract_scoreboard sb;
  logic [7:0]   frame_bytes[$];
  int           bytes_sent;
  logic [15:0]  srv_now;
  bit           tx_idle;
  bit           rx_idle;
  int           hold_token;
  int           hold_seen;
  int           hold_left;
  int           stall_left;
  int           quiet;
  hoth_record_t got;

  // receiver: checks accepted items and drives ready with stalls and holds
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind  = out_ch.kind;
      got.pkt   = out_ch.packet_number;
      got.src   = out_ch.source_address;
      got.dst   = out_ch.dest_address;
      got.sport = out_ch.source_tcp_port;
      got.dport = out_ch.dest_tcp_port;
      got.resp  = out_ch.is_response;
      got.ch    = out_ch.char_out;
      got.mal   = out_ch.malformed;
      got.last  = out_ch.run_last;
      sb.match_record(got);
    end
    if (hold_seen != hold_token) begin
      hold_seen    <= hold_token;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_reg(hoth_pkg::cfg_reg_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, v);
    if (idx == hoth_pkg::CFG_SERVER_PORT) srv_now = v;
    @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // stop offering, wait for every expected item, then let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // method < 0 gives an empty payload; cut > 0 truncates the frame to cut bytes
  task automatic make_frame(int ihl, int doff, int method, int n_lines, bit blank,
                            int body_len, int cut, logic [15:0] sp);
    int len;
    frame_bytes.delete();
    repeat (hoth_pkg::LINK_HEADER_BYTES) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back({4'($urandom), 4'(ihl)});
    len = (ihl >= hoth_pkg::MIN_HDR_WORDS) ? ihl * 4 - 1 : $urandom_range(0, 20);
    repeat (len) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(sp[15:8]);
    frame_bytes.push_back(sp[7:0]);
    if ($urandom_range(0, 3) == 0) begin
      frame_bytes.push_back(srv_now[15:8]);
      frame_bytes.push_back(srv_now[7:0]);
    end else begin
      repeat (2) frame_bytes.push_back(8'($urandom));
    end
    repeat (8) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back({4'(doff), 4'($urandom)});
    len = (doff >= hoth_pkg::MIN_HDR_WORDS) ? doff * 4 - 13 : $urandom_range(0, 10);
    repeat (len) frame_bytes.push_back(8'($urandom));
    if (method >= 0) begin
      frame_bytes.push_back(8'(method));
      for (int i = 0; i < n_lines; i++) begin
        len = (i == 0) ? $urandom_range(0, 10) : $urandom_range(1, 10);
        repeat (len) begin
          if ($urandom_range(0, 7) == 0) frame_bytes.push_back(8'($urandom));
          else frame_bytes.push_back(8'($urandom_range(32, 126)));
        end
        frame_bytes.push_back(hoth_pkg::CHAR_CR);
        // the byte after a CR is dropped, LF or not
        frame_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h0A);
      end
      if (blank) begin
        frame_bytes.push_back(hoth_pkg::CHAR_CR);
        frame_bytes.push_back(8'h0A);
      end
      repeat (body_len) frame_bytes.push_back(8'($urandom));
    end
    if (cut > 0 && cut < frame_bytes.size())
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
  endtask

  function automatic int pick_len_words();
    if ($urandom_range(0, 99) < 5) return $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) return $urandom_range(6, 15);
    return 5;
  endfunction

  task automatic random_frames(int n_bytes, bit idle_ok, bit with_hold);
    int stop_at;
    int m;
    int meth;
    bit held;
    stop_at = bytes_sent + n_bytes;
    held    = 1'b0;
    while (bytes_sent < stop_at) begin
      tx_idle = idle_ok && ($urandom_range(0, 3) != 0);
      rx_idle = idle_ok && ($urandom_range(0, 3) != 0);
      if (with_hold && !held && bytes_sent > stop_at - n_bytes / 2) begin
        hold_token <= hold_token + 1;
        held = 1'b1;
      end
      m = $urandom_range(0, 19);
      if (m <= 5) meth = hoth_pkg::CHAR_G;
      else if (m <= 10) meth = hoth_pkg::CHAR_H;
      else if (m <= 16) meth = hoth_pkg::CHAR_P;
      else if (m == 17) meth = $urandom_range(0, 255);
      else meth = -1;
      make_frame(pick_len_words(), pick_len_words(), meth, $urandom_range(0, 4),
                 $urandom_range(0, 4) != 0, $urandom_range(0, 12),
                 ($urandom_range(0, 6) == 0) ? $urandom_range(1, 90) : 0,
                 ($urandom_range(0, 2) == 0) ? srv_now : 16'($urandom));
      send_frame();
    end
  endtask

  initial begin
    sb               = new();
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = hoth_pkg::CFG_SERVER_PORT;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'd0;
    in_ch.frame_end  = 1'b0;
    out_ch.ready     = 1'b0;
    bytes_sent       = 0;
    srv_now          = 16'd80;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    hold_token       = 0;
    hold_seen        = 0;
    hold_left        = 0;
    stall_left       = 0;
    quiet            = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_reg(hoth_pkg::CFG_SERVER_PORT, 16'd80);
    set_reg(hoth_pkg::CFG_BODY_ENABLE, 16'd1);

    // directed frames
    make_frame(5, 5, hoth_pkg::CHAR_G, 1, 1, 0, 1, 16'h1234);   // one-byte frame
    frame_bytes[0] = 8'hFF;
    send_frame();
    make_frame(5, 5, hoth_pkg::CHAR_G, 1, 1, 0, 20, 16'h1234);  // ends inside IP header
    send_frame();
    make_frame(4, 5, hoth_pkg::CHAR_G, 1, 1, 0, 0, 16'h1234);   // IHL too small
    send_frame();
    make_frame(0, 5, hoth_pkg::CHAR_G, 1, 1, 0, 0, 16'h1234);
    send_frame();
    make_frame(5, 4, hoth_pkg::CHAR_G, 1, 1, 0, 0, 16'h1234);   // data offset too small
    send_frame();
    make_frame(5, 0, hoth_pkg::CHAR_G, 1, 1, 0, 0, 16'h1234);
    send_frame();
    make_frame(5, 5, -1, 0, 0, 0, 0, 16'd80);                   // empty payload, response
    send_frame();
    make_frame(5, 5, hoth_pkg::CHAR_G, 2, 1, 4, 0, 16'hFFFF);   // GET, body dropped
    send_frame();
    make_frame(5, 5, hoth_pkg::CHAR_H, 2, 0, 0, 0, 16'h0000);   // no blank line
    send_frame();
    make_frame(5, 5, hoth_pkg::CHAR_P, 1, 1, 6, 0, 16'hC001);   // POST with body
    send_frame();
    make_frame(5, 5, 8'h58, 1, 1, 3, 0, 16'hC001);              // not a method
    send_frame();
    make_frame(15, 15, hoth_pkg::CHAR_G, 1, 1, 0, 0, 16'd80);   // longest headers
    send_frame();
    make_frame(5, 5, hoth_pkg::CHAR_P, 1, 1, 0, 14 + 20 + 5, 16'd80); // ends inside TCP header
    send_frame();
    make_frame(5, 5, hoth_pkg::CHAR_P, 0, 1, 5, 0, 16'h0050);   // CR right after the method
    send_frame();
    random_frames(90, 1'b1, 1'b0);
    settle();

    set_reg(hoth_pkg::CFG_SERVER_PORT, 16'd0);
    set_reg(hoth_pkg::CFG_BODY_ENABLE, 16'd0);
    random_frames(60, 1'b1, 1'b0);
    settle();

    set_reg(hoth_pkg::CFG_SERVER_PORT, 16'hFFFF);
    set_reg(hoth_pkg::CFG_BODY_ENABLE, 16'd1);
    random_frames(160, 1'b1, 1'b1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    settle();

    // last part runs with no idling on either side
    set_reg(hoth_pkg::CFG_SERVER_PORT, 16'($urandom));
    random_frames(50, 1'b0, 1'b0);

    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
